// ===== hdl/lsfg_pkg.sv =====
// Shared types and codes for the LED strip frame generator.
// No dependencies; imported by every module of the block but the pixel RAM.
`timescale 1ns / 1ps

package lsfg_pkg;

  localparam int LSFG_MAX_LEDS = 32;

  localparam int LED_COUNT_W = 6;
  localparam int ORDER_W     = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int INDEX_W     = 5;
  localparam int CHAN_W      = 8;
  localparam int PIXEL_W     = 3 * CHAN_W;
  localparam int WORD_W      = 32;

  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RESET = 6'd32;

  // register indexes
  localparam logic CFG_LED_COUNT   = 1'b0;
  localparam logic CFG_COLOR_ORDER = 1'b1;

  // wire byte orders
  localparam logic [ORDER_W-1:0] ORDER_RGB = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_GRB = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_BGR = 2'd2;

  // command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_SHOW = 1'b1;

  // result kinds and status codes
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [WORD_W-1:0] WORD_START = 32'h0000_0000;
  localparam logic [WORD_W-1:0] WORD_END   = 32'hFFFF_FFFF;
  localparam logic [CHAN_W-1:0] BRIGHT_HDR = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_END
  } lsfg_state_e;

  typedef struct packed {
    logic              kind;
    logic              status;
    logic [WORD_W-1:0] word;
    logic              last;
  } lsfg_res_t;

  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } lsfg_fifo_stat_t;

endpackage

// ===== hdl/lsfg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lsfg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lsfg_ctrl.sv =====
// Command sequencer: config registers, pixel writes, frame walk and issue stage.
// Depends on lsfg_pkg; drives the pixel RAM and the output queue.
`timescale 1ns / 1ps

module lsfg_ctrl
  import lsfg_pkg::*;
#(
  parameter int MAX_LEDS = LSFG_MAX_LEDS,
  parameter int AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [INDEX_W-1:0]    pos_i,
  input  logic [CHAN_W-1:0]     red_i,
  input  logic [CHAN_W-1:0]     green_i,
  input  logic [CHAN_W-1:0]     blue_i,
  output logic                  ram_we_o,
  output logic [AW-1:0]         ram_waddr_o,
  output logic [PIXEL_W-1:0]    ram_wdata_o,
  output logic                  ram_re_o,
  output logic [AW-1:0]         ram_raddr_o,
  input  logic [PIXEL_W-1:0]    ram_rdata_i,
  input  lsfg_fifo_stat_t       fifo_stat_i,
  output logic                  push_valid_o,
  output lsfg_res_t             push_o
);

  localparam logic [LED_COUNT_W-1:0] MaxCount = LED_COUNT_W'(MAX_LEDS);

  lsfg_state_e state_q, state_d;

  logic [LED_COUNT_W-1:0] led_count_q;
  logic [ORDER_W-1:0]     order_q;
  logic [LED_COUNT_W-1:0] n_eff;
  logic [LED_COUNT_W-1:0] n_q;
  logic [LED_COUNT_W-1:0] idx_q, idx_d;
  logic [MAX_LEDS-1:0]    pix_vld_q;
  logic [7:0]             pos_ext;
  logic [7:0]             walk_ext;
  logic                   idx_ok;
  logic                   issue_ok;
  logic                   accept;
  logic                   walk_done;
  logic [PIXEL_W-1:0]     packed_pix;

  // issue stage
  logic p_valid_q, p_valid_d;
  logic p_kind_q, p_kind_d;
  logic p_status_q, p_status_d;
  logic p_last_q, p_last_d;
  logic p_mem_q, p_mem_d;
  logic p_ones_q, p_ones_d;
  logic p_pix_vld_q, p_pix_vld_d;

  assign n_eff = (led_count_q > MaxCount) ? MaxCount : led_count_q;
  assign idx_ok = {1'b0, pos_i} < n_eff;
  assign pos_ext = {3'b000, pos_i};
  assign walk_ext = {2'b00, idx_q};
  assign walk_done = (idx_q == n_q - 1'b1);

  assign issue_ok = ({1'b0, fifo_stat_i.count} + {2'b00, p_valid_q})
                    < (3'd2 + {2'b00, fifo_stat_i.pop});

  always_comb begin
    case (order_q)
      ORDER_GRB: packed_pix = {green_i, red_i, blue_i};
      ORDER_BGR: packed_pix = {blue_i, green_i, red_i};
      default:   packed_pix = {red_i, green_i, blue_i};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i == CMD_SHOW) begin
          state_d = (n_eff == '0) ? ST_END : ST_WALK;
        end
      end
      ST_WALK: begin
        if (issue_ok && walk_done) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (issue_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    accept      = 1'b0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_waddr_o = pos_ext[AW-1:0];
    ram_wdata_o = packed_pix;
    ram_raddr_o = walk_ext[AW-1:0];
    idx_d       = idx_q;
    p_valid_d   = 1'b0;
    p_kind_d    = KIND_FRAME;
    p_status_d  = STATUS_OK;
    p_last_d    = 1'b0;
    p_mem_d     = 1'b0;
    p_ones_d    = 1'b0;
    p_pix_vld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = issue_ok;
        accept     = in_valid_i && issue_ok;
        if (accept) begin
          p_valid_d = 1'b1;
          idx_d     = '0;
          if (cmd_i == CMD_SET) begin
            p_kind_d   = KIND_STATUS;
            p_status_d = idx_ok ? STATUS_OK : STATUS_RANGE;
            p_last_d   = 1'b1;
            ram_we_o   = idx_ok;
          end
        end
      end
      ST_WALK: begin
        if (issue_ok) begin
          p_valid_d   = 1'b1;
          p_mem_d     = 1'b1;
          p_pix_vld_d = pix_vld_q[ram_raddr_o];
          ram_re_o    = 1'b1;
          idx_d       = idx_q + 1'b1;
        end
      end
      ST_END: begin
        if (issue_ok) begin
          p_valid_d = 1'b1;
          p_ones_d  = 1'b1;
          p_last_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      led_count_q <= LED_COUNT_RESET;
      order_q     <= ORDER_RGB;
      pix_vld_q   <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      p_valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      p_valid_q <= p_valid_d;
      if (accept) begin
        n_q <= n_eff;
      end
      if (ram_we_o) begin
        pix_vld_q[ram_waddr_o] <= 1'b1;
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_LED_COUNT) begin
          led_count_q <= cfg_wdata_i[LED_COUNT_W-1:0];
        end else begin
          order_q <= cfg_wdata_i[ORDER_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_kind_q    <= p_kind_d;
    p_status_q  <= p_status_d;
    p_last_q    <= p_last_d;
    p_mem_q     <= p_mem_d;
    p_ones_q    <= p_ones_d;
    p_pix_vld_q <= p_pix_vld_d;
  end

  always_comb begin
    push_valid_o  = p_valid_q;
    push_o.kind   = p_kind_q;
    push_o.status = p_status_q;
    push_o.last   = p_last_q;
    if (p_mem_q) begin
      push_o.word = p_pix_vld_q ? {BRIGHT_HDR, ram_rdata_i} : {BRIGHT_HDR, {PIXEL_W{1'b0}}};
    end else begin
      push_o.word = p_ones_q ? WORD_END : WORD_START;
    end
  end

endmodule

// ===== hdl/lsfg_out.sv =====
// Two-entry result queue in front of the output stream.
// Depends on lsfg_pkg; fed by the command sequencer.
`timescale 1ns / 1ps

module lsfg_out
  import lsfg_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  lsfg_res_t       push_i,
  output lsfg_fifo_stat_t stat_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lsfg_res_t       out_o
);

  lsfg_res_t  e0_q, e0_d;
  lsfg_res_t  e1_q, e1_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop = (count_q != 2'd0) && out_ready_i;

  always_comb begin
    e0_d    = e0_q;
    e1_d    = e1_q;
    count_d = count_q;
    case (count_q)
      2'd0: begin
        if (push_valid_i) begin
          e0_d    = push_i;
          count_d = 2'd1;
        end
      end
      2'd1: begin
        if (pop && push_valid_i) begin
          e0_d = push_i;
        end else if (push_valid_i) begin
          e1_d    = push_i;
          count_d = 2'd2;
        end else if (pop) begin
          count_d = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          e0_d = e1_q;
          if (push_valid_i) begin
            e1_d = push_i;
          end else begin
            count_d = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign stat_o.count = count_q;
  assign stat_o.pop   = pop;
  assign out_valid_o  = (count_q != 2'd0);
  assign out_o        = e0_q;

endmodule

// ===== hdl/led_strip_frame_generator_core.sv =====
// LED strip frame generator: pixel store, set/show command handling, frame stream.
// A set is taken every cycle when the sink keeps up; its status passes issue stage and queue.
// A show emits the start word, one word per LED and the end word: min(led_count, MAX_LEDS)
// + 2 words, one per cycle at best, paced by the single pixel RAM read port and the queue.
// Reset restores led_count 32 and RGB order; per-entry valid flags make the whole
// store read black at once, with no clearing pass. Depends on lsfg_pkg and submodules.
`timescale 1ns / 1ps

module led_strip_frame_generator_core
  import lsfg_pkg::*;
#(
  parameter int MAX_LEDS = LSFG_MAX_LEDS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // index[4:0], red[12:5], green[20:13], blue[28:21], zero pad
  input  logic [31:0]           s_axis_tdata,
  // cmd
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status[0], frame_word[32:1], zero pad
  output logic [39:0]           m_axis_tdata,
  // kind
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [PIXEL_W-1:0] ram_rdata;
  lsfg_fifo_stat_t    fifo_stat;
  logic               push_valid;
  lsfg_res_t          push_res;
  lsfg_res_t          out_res;

  lsfg_ctrl #(
    .MAX_LEDS (MAX_LEDS),
    .AW       (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .pos_i        (s_axis_tdata[4:0]),
    .red_i        (s_axis_tdata[12:5]),
    .green_i      (s_axis_tdata[20:13]),
    .blue_i       (s_axis_tdata[28:21]),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .fifo_stat_i  (fifo_stat),
    .push_valid_o (push_valid),
    .push_o       (push_res)
  );

  lsfg_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_LEDS),
    .AW    (AW)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lsfg_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push_res),
    .stat_o       (fifo_stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (out_res)
  );

  assign m_axis_tdata = {7'b0, out_res.word, out_res.status};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
